FILE: hw/rtl/isdn_l1_pkg.sv
// Package for the ISDN layer-1 terminal activation machine.
// Holds the shared types, event and indication codes, and timer sizing.
// It depends on nothing else.
package isdn_l1_pkg;

   // Width of the activation timer counter (valid range 8 to 32).
   localparam int TimerBits = 16;

   // Width of the activation timeout register.
   localparam int TimeoutBits = 16;

   // Value of the activation timeout register after reset.
   localparam logic [TimeoutBits-1:0] TimeoutReset = 16'd7000;

   typedef enum logic [1:0] {
      CMD_INDICATION = 2'd0,
      CMD_ACTIVATE   = 2'd1,
      CMD_DEACTIVATE = 2'd2,
      CMD_TICK       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_F3 = 3'd0,
      ST_F4 = 3'd1,
      ST_F6 = 3'd2,
      ST_F7 = 3'd3,
      ST_F8 = 3'd4
   } line_state_type;

   // Transceiver indication codes.
   localparam logic [3:0] IndDp   = 4'd0;
   localparam logic [3:0] IndRsy  = 4'd4;
   localparam logic [3:0] IndAp   = 4'd8;
   localparam logic [3:0] IndAi8  = 4'd12;
   localparam logic [3:0] IndAi10 = 4'd13;

   // Indications passed up to layer two.
   localparam logic [1:0] UiNone  = 2'd0;
   localparam logic [1:0] UiAct   = 2'd1;
   localparam logic [1:0] UiDeact = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] ind_code;
   } req_type;

   typedef struct packed {
      logic [2:0] line_state;
      logic       issue_dr;
      logic       issue_pup;
      logic       issue_ar8;
      logic [1:0] upper_indication;
      logic       link_up;
   } rsp_type;

endpackage

FILE: hw/rtl/isdn_layer1_activation_fsm.sv
// Top level of the ISDN layer-1 terminal activation machine (F3, F4, F6, F7, F8).
// Each transfer on the request channel yields one transfer on the response channel.
// Depends on isdn_l1_pkg.
//
// A request is registered first in the input stage and then in the result stage,
// where its response becomes valid and is held until it transfers.
// Throughput: one request per cycle while the consumer does not stall the response.
// Reset: synchronous and active high. The machine returns to F3 with the timer
// stopped, the timeout register returns to 7000 ticks and both stages are emptied.
module isdn_layer1_activation_fsm
   import isdn_l1_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,

   input  logic                   csr_write,
   input  logic [TimeoutBits-1:0] csr_wdata
);

   // The timer load is computed at the wider of the two widths, so that a
   // narrow timer saturates and a wide timer simply zero-extends.
   localparam int LoadBits = (TimerBits > TimeoutBits) ? TimerBits : TimeoutBits;
   localparam logic [LoadBits-1:0] TimerMax =
      LoadBits'((64'd1 << TimerBits) - 64'd1);

   // Configuration register.
   logic [TimeoutBits-1:0] timeout_ms_ff;

   // Input stage.
   logic                   in_valid_ff;
   req_type                in_item_ff;

   // Machine state.
   line_state_type         state_ff, state_in;
   logic                   timer_run_ff, timer_run_in;
   logic [TimerBits-1:0]   timer_left_ff, timer_left_in;

   // Result stage.
   logic                   out_valid_ff;
   rsp_type                out_item_ff, out_item_in;

   logic                   advance;
   logic                   in_ready;
   logic                   dr_in, pup_in, ar8_in;
   logic [1:0]             ui_in;
   logic [LoadBits-1:0]    load_wide;
   logic [TimerBits-1:0]   timer_load;
   logic                   is_ai;

   // The pipeline moves whenever the result register is free or is being
   // drained in this cycle. The input stage stalls only when it holds an
   // item that cannot move forward.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign in_ready  = !in_valid_ff || advance;
   assign req_stall = !in_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // A zero timeout behaves like one, and a timeout that does not fit the
   // timer saturates at its largest count.
   always_comb begin
      load_wide = (timeout_ms_ff == '0) ? LoadBits'(1) : LoadBits'(timeout_ms_ff);
      if (load_wide > TimerMax) begin
         load_wide = TimerMax;
      end
      timer_load = load_wide[TimerBits-1:0];
   end

   assign is_ai = (in_item_ff.ind_code == IndAi8) || (in_item_ff.ind_code == IndAi10);

   // Next-state and result logic for the item in the input stage.
   always_comb begin
      state_in      = state_ff;
      timer_run_in  = timer_run_ff;
      timer_left_in = timer_left_ff;
      dr_in         = 1'b0;
      pup_in        = 1'b0;
      ar8_in        = 1'b0;
      ui_in         = UiNone;

      unique case (cmd_type'(in_item_ff.cmd))
         CMD_INDICATION: begin
            priority if (in_item_ff.ind_code == IndDp) begin
               // Dropping back to F3 tells layer two, but the timer keeps going.
               if (state_ff != ST_F3) begin
                  state_in = ST_F3;
                  ui_in    = UiDeact;
               end
            end else if (in_item_ff.ind_code == IndAp) begin
               state_in = ST_F6;
            end else if (is_ai) begin
               // Reaching F7 stops the timer and reports activation.
               if (state_ff == ST_F3 || state_ff == ST_F4 || state_ff == ST_F6) begin
                  state_in     = ST_F7;
                  timer_run_in = 1'b0;
                  ui_in        = UiAct;
               end
            end else if (in_item_ff.ind_code == IndRsy) begin
               if (state_ff == ST_F7) begin
                  state_in = ST_F8;
               end
            end else begin
               // Unknown indication codes are ignored.
               state_in = state_ff;
            end
         end
         CMD_ACTIVATE: begin
            // Only F3 answers an activate request: send DR, PUP, AR8 and arm the timer.
            if (state_ff == ST_F3) begin
               dr_in         = 1'b1;
               pup_in        = 1'b1;
               ar8_in        = 1'b1;
               timer_left_in = timer_load;
               timer_run_in  = 1'b1;
               state_in      = ST_F4;
            end
         end
         CMD_DEACTIVATE: begin
            // A deactivate request has no effect on the terminal side.
            state_in = state_ff;
         end
         CMD_TICK: begin
            if (timer_run_ff) begin
               if (timer_left_ff <= TimerBits'(1)) begin
                  timer_left_in = '0;
                  timer_run_in  = 1'b0;
                  // Expiry forces deactivation only in F4, F6 and F8.
                  if (state_ff == ST_F4 || state_ff == ST_F6 || state_ff == ST_F8) begin
                     dr_in    = 1'b1;
                     state_in = ST_F3;
                     ui_in    = UiDeact;
                  end
               end else begin
                  timer_left_in = timer_left_ff - TimerBits'(1);
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      out_item_in.line_state       = 3'(state_in);
      out_item_in.issue_dr         = dr_in;
      out_item_in.issue_pup        = pup_in;
      out_item_in.issue_ar8        = ar8_in;
      out_item_in.upper_indication = ui_in;
      out_item_in.link_up          = (state_in == ST_F7);
   end

   // Configuration register; write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff <= TimeoutReset;
      end else if (csr_write) begin
         timeout_ms_ff <= csr_wdata;
      end
   end

   // Input stage: takes a new request whenever it is empty or moving on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // Machine state changes exactly when an item moves into the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_F3;
         timer_run_ff  <= 1'b0;
         timer_left_ff <= '0;
      end else if (advance && in_valid_ff) begin
         state_ff      <= state_in;
         timer_run_ff  <= timer_run_in;
         timer_left_ff <= timer_left_in;
      end
   end

   // Result stage: holds its response until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule
